// ----- hw/rtl/lipu_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lipu_pkg
// Shared widths, codes and side-band types of the line intersect/project unit.
// -----------------------------------------------------------------------------
package lipu_pkg;

   // field widths
   localparam int COEF_WIDTH = 16;
   localparam int FRAC_BITS  = 16;
   localparam int FUNC_W     = 2;
   localparam int RES_W      = 48;
   localparam int SC_W       = 35;
   localparam int ST_W       = 2;

   // word widths, rounded up to whole bytes
   localparam int REQ_BITS = FUNC_W + 8 * COEF_WIDTH;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = 2 * RES_W + SC_W + ST_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // datapath widths
   localparam int P1_W  = 2 * COEF_WIDTH;           // coefficient product
   localparam int DET_W = 2 * COEF_WIDTH + 1;       // determinant, 2x2 numerators
   localparam int NUM_W = 3 * COEF_WIDTH;           // projection numerators
   localparam int MAG_W = NUM_W - 1;                // numerator magnitude
   localparam int DIV_W = MAG_W + FRAC_BITS;        // dividend and raw quotient
   localparam int DEN_W = 2 * COEF_WIDTH;           // divisor magnitude
   localparam int QW    = (DIV_W + 1 > RES_W + 1) ? DIV_W + 1 : RES_W + 1;
   localparam int SCC_W = 2 * COEF_WIDTH + 2;       // offset constant, unclamped
   localparam int SCX_W = ((SCC_W > SC_W) ? SCC_W : SC_W) + 1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INTERSECT = 2'd0,
      FUNC_PROJECT   = 2'd1,
      FUNC_OFFSET    = 2'd2,
      FUNC_RESERVED  = 2'd3
   } func_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK         = 2'd0,
      ST_PARALLEL   = 2'd1,
      ST_DEGENERATE = 2'd2,
      ST_SATURATED  = 2'd3
   } status_type;

   // side-band that travels beside the divider
   typedef struct packed {
      status_type        status;    // status before quotient saturation
      logic              use_div;   // result x/y come from the quotients
      logic              neg_x;
      logic              neg_y;
      logic [SC_W-1:0]   sc;
   } meta_type;

endpackage

// ----- hw/rtl/lipu_div.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lipu_div
// Pipelined restoring divider: one quotient bit per register stage.
// -----------------------------------------------------------------------------
module lipu_div (
   input  logic                         clock,
   input  logic                         enable,
   input  logic [lipu_pkg::DIV_W-1:0]   dividend,
   input  logic [lipu_pkg::DEN_W-1:0]   divisor,
   output logic [lipu_pkg::DIV_W-1:0]   quotient,
   output logic [lipu_pkg::DEN_W-1:0]   remainder,
   output logic [lipu_pkg::DEN_W-1:0]   divisor_out
);
   import lipu_pkg::*;

   logic [DIV_W-1:0] n_ff [1:DIV_W];
   logic [DEN_W-1:0] r_ff [1:DIV_W];
   logic [DEN_W-1:0] d_ff [1:DIV_W];

   // one trial subtract per stage, quotient bits shift in behind the dividend
   for (genvar k = 0; k < DIV_W; k++) begin : g_stage
      logic [DIV_W-1:0] n_cur;
      logic [DEN_W-1:0] r_cur;
      logic [DEN_W-1:0] d_cur;
      logic [DEN_W:0]   trial;
      logic [DEN_W:0]   diff;
      logic             ge;
      logic [DEN_W-1:0] r_in;
      logic [DIV_W-1:0] n_in;

      // stage zero takes the operands, later stages the previous registers
      if (k == 0) begin : g_head
         assign n_cur = dividend;
         assign r_cur = '0;
         assign d_cur = divisor;
      end else begin : g_tail
         assign n_cur = n_ff[k];
         assign r_cur = r_ff[k];
         assign d_cur = d_ff[k];
      end

      always_comb begin
         trial = {r_cur, n_cur[DIV_W-1]};
         diff  = trial - {1'b0, d_cur};
         ge    = (trial >= {1'b0, d_cur});
         r_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         n_in  = {n_cur[DIV_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            n_ff[k+1] <= n_in;
            r_ff[k+1] <= r_in;
            d_ff[k+1] <= d_cur;
         end
      end
   end

   assign quotient    = n_ff[DIV_W];
   assign remainder   = r_ff[DIV_W];
   assign divisor_out = d_ff[DIV_W];

endmodule

// ----- hw/rtl/line_intersect_project_unit.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// line_intersect_project_unit
// Line intersection (Cramer), point projection and line offset, fully pipelined.
// -----------------------------------------------------------------------------
// Pipeline: three product/sum stages, one divider stage per quotient bit, then
// the round/saturate output register. Throughput: one word per cycle unless the
// output stalls; the bit-serial divider chain sets the depth.
// Reset clears all valid bits; the pipeline stalls as a whole while the output
// word waits.
module line_intersect_project_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // func, first_a, first_b, first_c, second_a, second_b, second_c,
   // point_x, point_y (lowest bit up), zero fill
   input  logic [lipu_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // result_x, result_y, shifted_c, status (lowest bit up), zero fill
   output logic [lipu_pkg::RSP_W-1:0]  rsp_tdata
);
   import lipu_pkg::*;

   localparam int CW = COEF_WIDTH;

   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------- input fields
   logic [FUNC_W-1:0]      f_func;
   logic signed [CW-1:0]   f_a1, f_b1, f_c1, f_a2, f_b2, f_c2, f_px, f_py;
   always_comb begin
      f_func = req_tdata[FUNC_W-1:0];
      f_a1   = req_tdata[FUNC_W + 0*CW +: CW];
      f_b1   = req_tdata[FUNC_W + 1*CW +: CW];
      f_c1   = req_tdata[FUNC_W + 2*CW +: CW];
      f_a2   = req_tdata[FUNC_W + 3*CW +: CW];
      f_b2   = req_tdata[FUNC_W + 4*CW +: CW];
      f_c2   = req_tdata[FUNC_W + 5*CW +: CW];
      f_px   = req_tdata[FUNC_W + 6*CW +: CW];
      f_py   = req_tdata[FUNC_W + 7*CW +: CW];
   end

   // ---------------- stage 1: coefficient products
   logic                   v1_ff;
   logic [FUNC_W-1:0]      func1_ff;
   logic                   deg1_ff, deg2_ff;
   logic signed [CW-1:0]   c1_1_ff, px1_ff, py1_ff;
   logic signed [P1_W-1:0] a1b2_ff, b1a2_ff, b1c2_ff, c1b2_ff, c1a2_ff, a1c2_ff;
   logic signed [P1_W-1:0] aa_ff, bb_ff, ab_ff, a1c1_ff, b1c1_ff, a1px_ff, b1py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func1_ff <= f_func;
         deg1_ff  <= (f_a1 == '0) && (f_b1 == '0);
         deg2_ff  <= (f_a2 == '0) && (f_b2 == '0);
         c1_1_ff  <= f_c1;
         px1_ff   <= f_px;
         py1_ff   <= f_py;
         a1b2_ff  <= P1_W'(f_a1) * P1_W'(f_b2);
         b1a2_ff  <= P1_W'(f_b1) * P1_W'(f_a2);
         b1c2_ff  <= P1_W'(f_b1) * P1_W'(f_c2);
         c1b2_ff  <= P1_W'(f_c1) * P1_W'(f_b2);
         c1a2_ff  <= P1_W'(f_c1) * P1_W'(f_a2);
         a1c2_ff  <= P1_W'(f_a1) * P1_W'(f_c2);
         aa_ff    <= P1_W'(f_a1) * P1_W'(f_a1);
         bb_ff    <= P1_W'(f_b1) * P1_W'(f_b1);
         ab_ff    <= P1_W'(f_a1) * P1_W'(f_b1);
         a1c1_ff  <= P1_W'(f_a1) * P1_W'(f_c1);
         b1c1_ff  <= P1_W'(f_b1) * P1_W'(f_c1);
         a1px_ff  <= P1_W'(f_a1) * P1_W'(f_px);
         b1py_ff  <= P1_W'(f_b1) * P1_W'(f_py);
      end
   end

   // ---------------- stage 2: determinants, second products, offset sum
   logic                    v2_ff;
   logic [FUNC_W-1:0]       func2_ff;
   logic                    deg1_2_ff, deg2_2_ff;
   logic signed [DET_W-1:0] deti_ff, nxi_ff, nyi_ff, detp_ff;
   logic signed [NUM_W-1:0] bbpx_ff, abpy_ff, aapy_ff, abpx_ff, a1c1_2_ff, b1c1_2_ff;
   logic signed [SCC_W-1:0] scv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func2_ff  <= func1_ff;
         deg1_2_ff <= deg1_ff;
         deg2_2_ff <= deg2_ff;
         deti_ff   <= DET_W'(a1b2_ff) - DET_W'(b1a2_ff);
         nxi_ff    <= DET_W'(b1c2_ff) - DET_W'(c1b2_ff);
         nyi_ff    <= DET_W'(c1a2_ff) - DET_W'(a1c2_ff);
         detp_ff   <= DET_W'(aa_ff) + DET_W'(bb_ff);
         bbpx_ff   <= NUM_W'(bb_ff) * NUM_W'(px1_ff);
         abpy_ff   <= NUM_W'(ab_ff) * NUM_W'(py1_ff);
         aapy_ff   <= NUM_W'(aa_ff) * NUM_W'(py1_ff);
         abpx_ff   <= NUM_W'(ab_ff) * NUM_W'(px1_ff);
         a1c1_2_ff <= NUM_W'(a1c1_ff);
         b1c1_2_ff <= NUM_W'(b1c1_ff);
         scv_ff    <= SCC_W'(c1_1_ff) - SCC_W'(a1px_ff) - SCC_W'(b1py_ff);
      end
   end

   // ---------------- stage 3: select operands, magnitudes, early status
   logic signed [NUM_W-1:0] num_x, num_y, proj_x, proj_y;
   logic signed [DET_W-1:0] den;
   logic                    den_neg;
   logic [NUM_W-1:0]        mag_x_full, mag_y_full;
   logic [DET_W-1:0]        den_full;
   logic signed [SCX_W-1:0] scx, sc_max, sc_min;
   logic [SC_W-1:0]         sc_val;
   logic                    sc_sat;
   meta_type                meta_in;

   always_comb begin
      proj_x   = bbpx_ff - abpy_ff - a1c1_2_ff;
      proj_y   = aapy_ff - abpx_ff - b1c1_2_ff;
      num_x    = NUM_W'(nxi_ff);
      num_y    = NUM_W'(nyi_ff);
      den      = deti_ff;
      if (func_type'(func2_ff) == FUNC_PROJECT) begin
         num_x = proj_x;
         num_y = proj_y;
         den   = detp_ff;
      end
      den_neg    = den[DET_W-1];
      mag_x_full = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
      mag_y_full = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
      den_full   = den_neg ? DET_W'(-den) : DET_W'(den);

      // clamp the offset constant
      scx    = SCX_W'(scv_ff);
      sc_max = SCX_W'({1'b0, {(SC_W-1){1'b1}}});
      sc_min = -sc_max - SCX_W'(1);
      sc_sat = 1'b0;
      sc_val = scx[SC_W-1:0];
      if (scx > sc_max) begin
         sc_val = sc_max[SC_W-1:0];
         sc_sat = 1'b1;
      end else if (scx < sc_min) begin
         sc_val = sc_min[SC_W-1:0];
         sc_sat = 1'b1;
      end

      meta_in.status  = ST_OK;
      meta_in.use_div = 1'b0;
      meta_in.neg_x   = num_x[NUM_W-1] ^ den_neg;
      meta_in.neg_y   = num_y[NUM_W-1] ^ den_neg;
      meta_in.sc      = '0;
      unique case (func2_ff)
         FUNC_INTERSECT: begin
            if (deg1_2_ff || deg2_2_ff) begin
               meta_in.status = ST_DEGENERATE;
            end else if (deti_ff == '0) begin
               meta_in.status = ST_PARALLEL;
            end else begin
               meta_in.use_div = 1'b1;
            end
         end
         FUNC_PROJECT: begin
            if (deg1_2_ff) begin
               meta_in.status = ST_DEGENERATE;
            end else begin
               meta_in.use_div = 1'b1;
            end
         end
         FUNC_OFFSET: begin
            if (deg1_2_ff) begin
               meta_in.status = ST_DEGENERATE;
            end else begin
               meta_in.sc     = sc_val;
               meta_in.status = sc_sat ? ST_SATURATED : ST_OK;
            end
         end
         default: begin
            meta_in.status = ST_DEGENERATE;
         end
      endcase
   end

   logic             v3_ff;
   meta_type         meta3_ff;
   logic [DIV_W-1:0] dvx_ff, dvy_ff;
   logic [DEN_W-1:0] dsr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         meta3_ff <= meta_in;
         dvx_ff   <= DIV_W'({mag_x_full[MAG_W-1:0], {FRAC_BITS{1'b0}}});
         dvy_ff   <= DIV_W'({mag_y_full[MAG_W-1:0], {FRAC_BITS{1'b0}}});
         dsr_ff   <= den_full[DEN_W-1:0];
      end
   end

   // ---------------- divider chain with side-band delay line
   logic [DIV_W-1:0] qx, qy;
   logic [DEN_W-1:0] rx_rem, ry_rem, dx_out, dy_out;

   lipu_div u_div_x (
      .clock       (clock),
      .enable      (en),
      .dividend    (dvx_ff),
      .divisor     (dsr_ff),
      .quotient    (qx),
      .remainder   (rx_rem),
      .divisor_out (dx_out)
   );

   lipu_div u_div_y (
      .clock       (clock),
      .enable      (en),
      .dividend    (dvy_ff),
      .divisor     (dsr_ff),
      .quotient    (qy),
      .remainder   (ry_rem),
      .divisor_out (dy_out)
   );

   logic     vd_ff [1:DIV_W];
   meta_type md_ff [1:DIV_W];

   for (genvar k = 0; k < DIV_W; k++) begin : g_meta
      logic     vd_cur;
      meta_type md_cur;

      // stage zero takes the stage-3 registers
      if (k == 0) begin : g_head
         assign vd_cur = v3_ff;
         assign md_cur = meta3_ff;
      end else begin : g_tail
         assign vd_cur = vd_ff[k];
         assign md_cur = md_ff[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k+1] <= 1'b0;
         end else if (en) begin
            vd_ff[k+1] <= vd_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            md_ff[k+1] <= md_cur;
         end
      end
   end

   // ---------------- round half away from zero, saturate, apply sign
   function automatic logic [RES_W:0] round_sat(
      input logic [DIV_W-1:0] q,
      input logic [DEN_W-1:0] r,
      input logic [DEN_W-1:0] d,
      input logic             neg
   );
      logic          up;
      logic [QW-1:0] qr, lim, v;
      logic          sat;
      logic [RES_W-1:0] res;
      up  = ({r, 1'b0} >= {1'b0, d});
      qr  = QW'(q) + QW'(up);
      lim = neg ? (QW'(1) << (RES_W - 1)) : ((QW'(1) << (RES_W - 1)) - QW'(1));
      sat = (qr > lim);
      v   = sat ? lim : qr;
      res = neg ? (RES_W'(0) - v[RES_W-1:0]) : v[RES_W-1:0];
      return {sat, res};
   endfunction

   logic [RES_W:0]   fx, fy;
   logic [RES_W-1:0] res_x, res_y;
   status_type       st_out;
   meta_type         mo;

   always_comb begin
      mo     = md_ff[DIV_W];
      fx     = round_sat(qx, rx_rem, dx_out, mo.neg_x);
      fy     = round_sat(qy, ry_rem, dy_out, mo.neg_y);
      res_x  = '0;
      res_y  = '0;
      st_out = mo.status;
      if (mo.use_div) begin
         res_x = fx[RES_W-1:0];
         res_y = fy[RES_W-1:0];
         if (fx[RES_W] || fy[RES_W]) begin
            st_out = ST_SATURATED;
         end
      end
   end

   // ---------------- output register
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vd_ff[DIV_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= RSP_W'({st_out, mo.sc, res_y, res_x});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
